// ===== rtl/core/sbsc_pkg.sv =====
// Shared types, symmetry codes and cell mapping for the bitboard canonicalizer.
`timescale 1ns / 1ps
`default_nettype none
package sbsc_pkg;

  localparam int BOARD_W = 64;
  localparam int CELL_W  = 6;
  localparam int CODE_W  = 3;
  localparam int N_SYM   = 8;

  localparam logic [CODE_W-1:0] SYM_IDENTITY = 3'd0;
  localparam logic [CODE_W-1:0] SYM_R3       = 3'd1;
  localparam logic [CODE_W-1:0] SYM_R2       = 3'd2;
  localparam logic [CODE_W-1:0] SYM_R        = 3'd3;
  localparam logic [CODE_W-1:0] SYM_F        = 3'd4;
  localparam logic [CODE_W-1:0] SYM_RF       = 3'd5;
  localparam logic [CODE_W-1:0] SYM_R2F      = 3'd6;
  localparam logic [CODE_W-1:0] SYM_R3F      = 3'd7;

  localparam logic REG_BOARD_SIDE = 1'b0;
  localparam logic [3:0] BOARD_SIDE_RESET = 4'd3;

  typedef struct packed {
    logic [BOARD_W-1:0] board;
    logic [CODE_W-1:0]  code;
  } cand_t;

  // destination cell of (r, c) under a symmetry on an n-by-n board
  function automatic int map_cell(input logic [CODE_W-1:0] code, input int r,
                                  input int c, input int n);
    int m;
    int dst;
    m = n - 1;
    case (code)
      SYM_R3:  dst = (m - c) * n + r;
      SYM_R2:  dst = (m - r) * n + (m - c);
      SYM_R:   dst = c * n + (m - r);
      SYM_F:   dst = r * n + (m - c);
      SYM_RF:  dst = (m - c) * n + (m - r);
      SYM_R2F: dst = (m - r) * n + c;
      default: dst = c * n + r;
    endcase
    return dst;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/square_bitboard_symmetry_canonicalizer.sv =====
// Registered stages in order: mask, images, then three registered levels
// of the 8-way minimum tree.
// Throughput: one board per cycle; a stall at the output holds every stage at once.
// Reset (synchronous, active high) empties the pipeline and sets board_side to 3.
// Top level: configuration register, side clamp and pipeline wiring.
`timescale 1ns / 1ps
`default_nettype none
module square_bitboard_symmetry_canonicalizer #(
  parameter int MAX_SIDE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] board_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      canonical_board,
  output logic [2:0]       symmetry_code
);
  import sbsc_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  logic [3:0]        board_side;
  logic [SIDE_W-1:0] side_eff;
  logic              en;
  logic              wr_req;
  logic              img_valid;
  logic              l1_valid;
  logic              l2_valid;
  cand_t             img_cand [N_SYM];
  cand_t             l1_cand  [N_SYM/2];
  cand_t             l2_cand  [N_SYM/4];
  cand_t             fin_cand [1];

  assign pready = 1'b1;
  assign wr_req = psel && penable && pwrite && (paddr[2] == REG_BOARD_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      board_side <= BOARD_SIDE_RESET;
    end else if (wr_req) begin
      board_side <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_BOARD_SIDE) ? {28'd0, board_side} : 32'd0;

  always_comb begin
    if (board_side == 4'd0) begin
      side_eff = SIDE_W'(1);
    end else if (board_side > 4'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = board_side[SIDE_W-1:0];
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  sbsc_image #(
    .MAX_SIDE (MAX_SIDE),
    .SIDE_W   (SIDE_W)
  ) u_image (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .board_bits (board_bits),
    .side_eff   (side_eff),
    .cand_valid (img_valid),
    .cand       (img_cand)
  );

  sbsc_min_stage #(.N_IN(N_SYM)) u_min8 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (img_valid),
    .cin       (img_cand),
    .out_valid (l1_valid),
    .cout      (l1_cand)
  );

  sbsc_min_stage #(.N_IN(N_SYM/2)) u_min4 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (l1_valid),
    .cin       (l1_cand),
    .out_valid (l2_valid),
    .cout      (l2_cand)
  );

  sbsc_min_stage #(.N_IN(N_SYM/4)) u_min2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (l2_valid),
    .cin       (l2_cand),
    .out_valid (out_valid),
    .cout      (fin_cand)
  );

  assign canonical_board = fin_cand[0].board;
  assign symmetry_code   = fin_cand[0].code;

endmodule
`default_nettype wire

// ===== rtl/core/sbsc_image.sv =====
// Input masking stage and image stage: forms the eight symmetric images of a board.
`timescale 1ns / 1ps
`default_nettype none
module sbsc_image #(
  parameter int MAX_SIDE = 8,
  parameter int SIDE_W   = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [sbsc_pkg::BOARD_W-1:0] board_bits,
  input  wire logic [SIDE_W-1:0]           side_eff,
  output logic                             cand_valid,
  output sbsc_pkg::cand_t                  cand [sbsc_pkg::N_SYM]
);
  import sbsc_pkg::*;

  logic               v1;
  logic [BOARD_W-1:0] b1;
  logic [SIDE_W-1:0]  side1;
  logic [BOARD_W-1:0] mask;
  logic [BOARD_W-1:0] img [N_SYM];

  always_comb begin
    mask = '0;
    for (int nn = 1; nn <= MAX_SIDE; nn++) begin
      if (side_eff == SIDE_W'(nn)) begin
        mask = (nn * nn >= BOARD_W) ? '1 : ((64'd1 << (nn * nn)) - 64'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1    <= board_bits & mask;
      side1 <= side_eff;
    end
  end

  // each side value gives a fixed bit permutation; select by side
  always_comb begin
    for (int k = 0; k < N_SYM; k++) begin
      img[k] = '0;
    end
    img[0] = b1;
    for (int nn = 1; nn <= MAX_SIDE; nn++) begin
      if (side1 == SIDE_W'(nn)) begin
        for (int k = 1; k < N_SYM; k++) begin
          for (int r = 0; r < nn; r++) begin
            for (int c = 0; c < nn; c++) begin
              img[k][CELL_W'(map_cell(CODE_W'(k), r, c, nn))] = b1[CELL_W'(r * nn + c)];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (en) begin
      cand_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_SYM; k++) begin
        cand[k].board <= img[k];
        cand[k].code  <= CODE_W'(k);
      end
    end
  end

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) rst |=> !v1 && !cand_valid)
    else $error("pipeline valid not cleared by reset");
  a_pop_rot: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> $countones(cand[SYM_R].board) == $countones(cand[SYM_IDENTITY].board))
    else $error("rotation image changed cell count");
  a_pop_diag: assert property (@(posedge clk) disable iff (rst)
    cand_valid |-> $countones(cand[SYM_R3F].board) == $countones(cand[SYM_IDENTITY].board))
    else $error("transpose image changed cell count");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/sbsc_min_stage.sv =====
// One registered level of the minimum tree; the earlier candidate wins a tie.
`timescale 1ns / 1ps
`default_nettype none
module sbsc_min_stage #(
  parameter int N_IN = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  sbsc_pkg::cand_t     cin  [N_IN],
  output logic                out_valid,
  output sbsc_pkg::cand_t     cout [N_IN/2]
);
  import sbsc_pkg::*;

  localparam int N_OUT = N_IN / 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_OUT; i++) begin
        cout[i] <= (cin[2*i+1].board < cin[2*i].board) ? cin[2*i+1] : cin[2*i];
      end
    end
  end

`ifndef SYNTH
  a_min_le_first: assert property (@(posedge clk) disable iff (rst)
    en && in_valid |=> cout[0].board <= $past(cin[0].board))
    else $error("pair minimum exceeds its left operand");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/square_bitboard_symmetry_canonicalizer_tb.sv =====
// Testbench for the square bitboard symmetry canonicalizer: stimulus, scoreboard and checks.
`timescale 1ns / 1ps
module square_bitboard_symmetry_canonicalizer_tb;
  import sbsc_pkg::*;

  localparam int MAX_SIDE = 8;
  localparam logic [2:0] ADDR_BOARD_SIDE = {REG_BOARD_SIDE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int REQS_PER_PHASE = 119;
  localparam int N_PHASES = 16;

  class canon_scoreboard;
    logic [3:0] side_reg;
    cand_t      expected_q[$];
    int         errors;

    function new();
      side_reg = BOARD_SIDE_RESET;
      errors = 0;
    endfunction

    function int side();
      if (side_reg == 4'd0) return 1;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return int'(side_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // image of a board under one symmetry: optional transpose, then row/column flips
    static function logic [63:0] transform(logic [2:0] sym, logic [63:0] b, int n);
      logic swap;
      logic flip_row;
      logic flip_col;
      logic [63:0] img;
      int m;
      int a;
      int d;
      int dr;
      int dc;
      m = n - 1;
      img = '0;
      case (sym)
        SYM_R3:  {swap, flip_row, flip_col} = 3'b110;
        SYM_R2:  {swap, flip_row, flip_col} = 3'b011;
        SYM_R:   {swap, flip_row, flip_col} = 3'b101;
        SYM_F:   {swap, flip_row, flip_col} = 3'b001;
        SYM_RF:  {swap, flip_row, flip_col} = 3'b111;
        SYM_R2F: {swap, flip_row, flip_col} = 3'b010;
        SYM_R3F: {swap, flip_row, flip_col} = 3'b100;
        default: {swap, flip_row, flip_col} = 3'b000;
      endcase
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          if (b[r*n+c]) begin
            a = swap ? c : r;
            d = swap ? r : c;
            dr = flip_row ? m - a : a;
            dc = flip_col ? m - d : d;
            img[dr*n+dc] = 1'b1;
          end
        end
      end
      return img;
    endfunction

    function void note_board(logic [63:0] bits);
      cand_t best;
      logic [63:0] img;
      int n;
      n = side();
      if (n < 8) bits &= (64'd1 << (n * n)) - 64'd1;
      best.board = bits;
      best.code = SYM_IDENTITY;
      for (int k = 1; k < N_SYM; k++) begin
        img = transform(CODE_W'(k), bits, n);
        if (img < best.board) begin
          best.board = img;
          best.code = CODE_W'(k);
        end
      end
      expected_q.insert(expected_q.size(), best);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_result(logic [63:0] board, logic [2:0] code);
      cand_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result board %h code %0d", board, code));
        return;
      end
      want = expected_q.pop_front();
      if (board !== want.board)
        report($sformatf("canonical_board %h, expected %h", board, want.board));
      if (code !== want.code)
        report($sformatf("symmetry_code %0d, expected %0d", code, want.code));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] board_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [63:0] canonical_board;
  logic [2:0]  symmetry_code;

  int idle_pct = 0;
  int stall_pct = 0;
  canon_scoreboard sb = new();

  square_bitboard_symmetry_canonicalizer #(.MAX_SIDE(MAX_SIDE)) u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .board_bits(board_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .canonical_board(canonical_board), .symmetry_code(symmetry_code)
  );

  always #4 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_board(board_bits);
      if (out_valid && out_ready) sb.check_result(canonical_board, symmetry_code);
    end
  end

  task automatic send_board(input logic [63:0] bits);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    board_bits = bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_BOARD_SIDE) sb.side_reg = data[3:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apb_check_side();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_BOARD_SIDE;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[3:0] !== sb.side_reg)
      sb.report($sformatf("board_side reads %0d, expected %0d", prdata[3:0], sb.side_reg));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_side(input logic [3:0] value);
    wait_idle();
    apb_write(ADDR_BOARD_SIDE, {28'd0, value});
    apb_check_side();
  endtask

  function automatic logic [63:0] rand_board(int n);
    logic [63:0] b;
    logic [63:0] mask;
    int cells;
    cells = n * n;
    mask = (n < 8) ? (64'd1 << cells) - 64'd1 : '1;
    case ($urandom_range(9))
      0, 1, 2: b = {$urandom, $urandom};
      3, 4:    b = {$urandom, $urandom} & mask;
      5: begin
        b = '0;
        repeat ($urandom_range(3, 1)) b[$urandom_range(cells - 1)] = 1'b1;
      end
      6, 7: begin
        b = {$urandom, $urandom} & mask;
        b |= canon_scoreboard::transform(CODE_W'($urandom_range(7, 1)), b, n);
      end
      8: begin
        b = mask;
        repeat ($urandom_range(3, 1)) b[$urandom_range(cells - 1)] = 1'b0;
      end
      default: b = $urandom_range(1) ? '1 : '0;
    endcase
    return b;
  endfunction

  initial begin
    logic [3:0] phase_side[N_PHASES];
    phase_side = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5,
                   4'd6, 4'd7, 4'd8, 4'd9, 4'd12, 4'd8, 4'd1, 4'd3};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // side 3 out of reset; bits past cell 8 must be dropped
    apb_check_side();
    send_board('0);
    send_board('1);
    send_board(64'd1);
    send_board(64'h100);
    send_board(64'h200);

    set_side(4'd8);
    send_board('1);
    send_board(64'h8000_0000_0000_0000);
    send_board(64'h0000_0000_0000_0080);
    send_board(64'h0100_0000_0000_0000);
    send_board(64'hAAAA_AAAA_AAAA_AAAA);
    send_board(64'h55AA_55AA_55AA_55AA);
    send_board(64'h8100_0000_0000_0081);

    // zero side behaves as one, oversize side as eight
    set_side(4'd0);
    send_board(64'd1);
    send_board(64'hFFFF_FFFF_FFFF_FFFE);
    set_side(4'd15);
    send_board(64'h8000_0000_0000_0000);
    send_board(64'h0000_0000_0000_FF00);

    // write to an unused register index must not touch board_side
    wait_idle();
    apb_write(ADDR_UNMAPPED, 32'd2);
    apb_check_side();
    send_board(64'h8000_0000_0000_0001);

    set_side(4'd2);
    send_board(64'd1);
    send_board(64'd2);
    send_board(64'd4);
    send_board(64'd8);
    send_board(64'hFFFF_FFFF_FFFF_FFF6);

    for (int p = 0; p < N_PHASES; p++) begin
      set_side(phase_side[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      repeat (REQS_PER_PHASE) send_board(rand_board(sb.side()));
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sbsc_pkg.sv
rtl/core/sbsc_image.sv
rtl/core/sbsc_min_stage.sv
rtl/core/square_bitboard_symmetry_canonicalizer.sv
tb/sv/square_bitboard_symmetry_canonicalizer_tb.sv
